[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk, held off while rst is high.
`define ADCM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every rising edge of clk, reset included.
`define ADCM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/adcm_pkg.sv]
package adcm_pkg;

  localparam int XW       = 36;
  localparam int ZW       = 34;
  localparam int SATW     = 36;
  localparam int ANGW     = 18;
  localparam int ATAN_LEN = 24;

  typedef struct packed {
    logic signed [15:0] speed_command;
    logic signed [15:0] turn_rate_command;
  } cmd_t;

  typedef struct packed {
    logic signed [15:0] motor_drive;
    logic signed [15:0] servo_drive;
  } drive_t;

  typedef struct packed {
    logic signed [15:0] speed_offset;
    logic signed [15:0] speed_scale;
    logic signed [15:0] angle_offset;
    logic signed [15:0] angle_scale;
    logic        [14:0] forward_dead_band;
    logic signed [15:0] backward_dead_band;
    logic        [15:0] axle_distance;
  } cfg_t;

  typedef enum logic [2:0] {
    REG_SPEED_OFFSET       = 3'd0,
    REG_SPEED_SCALE        = 3'd1,
    REG_ANGLE_OFFSET       = 3'd2,
    REG_ANGLE_SCALE        = 3'd3,
    REG_FORWARD_DEAD_BAND  = 3'd4,
    REG_BACKWARD_DEAD_BAND = 3'd5,
    REG_AXLE_DISTANCE      = 3'd6
  } reg_idx_t;

  // atan(2^-i) in Q2.30, truncated
  localparam logic signed [ZW-1:0] ATAN_TAB [ATAN_LEN] = '{
    34'sh3243F6A8, 34'sh1DAC6705, 34'sh0FADBAFC, 34'sh07F56EA6,
    34'sh03FEAB76, 34'sh01FFD55B, 34'sh00FFFAAA, 34'sh007FFF55,
    34'sh003FFFEA, 34'sh001FFFFD, 34'sh000FFFFF, 34'sh0007FFFF,
    34'sh0003FFFF, 34'sh0001FFFF, 34'sh0000FFFF, 34'sh00007FFF,
    34'sh00003FFF, 34'sh00001FFF, 34'sh00000FFF, 34'sh000007FF,
    34'sh000003FF, 34'sh000001FF, 34'sh000000FF, 34'sh0000007F
  };

  function automatic logic signed [15:0] sat16(input logic signed [SATW-1:0] v);
    logic signed [15:0] r;
    if (v > SATW'(32767)) begin
      r = 16'sh7FFF;
    end else if (v < -SATW'(32768)) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

[rtl/adcm_front.sv]
module adcm_front
  import adcm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 cmd_valid,
  input  cmd_t                 cmd,
  input  cfg_t                 cfg,
  output logic                 valid,
  output logic signed [XW-1:0] x,
  output logic signed [XW-1:0] y,
  output logic                 zero,
  output logic signed [32:0]   motor_prod
);

  logic               valid1;
  logic signed [15:0] v1;
  logic signed [15:0] w1;
  logic signed [15:0] v_db;

  logic signed [32:0]   y_prod;
  logic signed [16:0]   v_ext;
  logic signed [16:0]   v_mag;
  logic signed [XW-1:0] y_ext;
  logic signed [16:0]   v_diff;

  always_comb begin
    v_db = cmd.speed_command;
    if ((cmd.speed_command > 16'sd0 &&
         cmd.speed_command < $signed({1'b0, cfg.forward_dead_band})) ||
        (cmd.speed_command < 16'sd0 && cmd.speed_command > cfg.backward_dead_band)) begin
      v_db = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else if (en) begin
      valid1 <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v1 <= v_db;
      w1 <= cmd.turn_rate_command;
    end
  end

  assign y_prod = $signed({1'b0, cfg.axle_distance}) * w1;
  assign v_ext  = {v1[15], v1};
  assign v_mag  = v1[15] ? -v_ext : v_ext;
  assign y_ext  = {{(XW-33){y_prod[32]}}, y_prod};
  assign v_diff = v_ext - {cfg.speed_offset[15], cfg.speed_offset};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x          <= {{(XW-29){1'b0}}, v_mag, 12'b0};
      y          <= v1[15] ? -y_ext : y_ext;
      zero       <= (v1 == 16'sd0) || (w1 == 16'sd0) || (cfg.axle_distance == 16'd0);
      motor_prod <= v_diff * cfg.speed_scale;
    end
  end

endmodule

[rtl/adcm_cordic.sv]
`include "assert_macros.svh"

module adcm_cordic
  import adcm_pkg::*;
#(
  parameter int STAGES = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [XW-1:0] in_x,
  input  logic signed [XW-1:0] in_y,
  input  logic                 in_zero,
  input  logic signed [32:0]   in_motor,
  output logic                 out_valid,
  output logic signed [ZW-1:0] out_z,
  output logic                 out_zero,
  output logic signed [32:0]   out_motor
);

  logic                 valid_s [STAGES+1];
  logic signed [XW-1:0] x_s     [STAGES+1];
  logic signed [XW-1:0] y_s     [STAGES+1];
  logic signed [ZW-1:0] z_s     [STAGES+1];
  logic                 zero_s  [STAGES+1];
  logic signed [32:0]   motor_s [STAGES+1];

  assign valid_s[0] = in_valid;
  assign x_s[0]     = in_x;
  assign y_s[0]     = in_y;
  assign z_s[0]     = '0;
  assign zero_s[0]  = in_zero;
  assign motor_s[0] = in_motor;

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;

    assign dx = y_s[i] >>> i;
    assign dy = x_s[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_s[i+1] <= 1'b0;
      end else if (en) begin
        valid_s[i+1] <= valid_s[i];
      end
    end

    // rotate toward the x axis
    always_ff @(posedge clk) begin
      if (en) begin
        if (!y_s[i][XW-1]) begin
          x_s[i+1] <= x_s[i] + dx;
          y_s[i+1] <= y_s[i] - dy;
          z_s[i+1] <= z_s[i] + ATAN_TAB[i];
        end else begin
          x_s[i+1] <= x_s[i] - dx;
          y_s[i+1] <= y_s[i] + dy;
          z_s[i+1] <= z_s[i] - ATAN_TAB[i];
        end
        zero_s[i+1]  <= zero_s[i];
        motor_s[i+1] <= motor_s[i];
      end
    end
  end

  assign out_valid = valid_s[STAGES];
  assign out_z     = z_s[STAGES];
  assign out_zero  = zero_s[STAGES];
  assign out_motor = motor_s[STAGES];

  `ADCM_ASSERT(a_cordic_x_positive, valid_s[STAGES] && !zero_s[STAGES] |-> x_s[STAGES] > 0, "cordic x lost its sign")

endmodule

[rtl/adcm_back.sv]
`include "assert_macros.svh"

module adcm_back
  import adcm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [ZW-1:0] in_z,
  input  logic                 in_zero,
  input  logic signed [32:0]   in_motor,
  input  cfg_t                 cfg,
  output logic                 out_valid,
  output drive_t               out_drive
);

  logic signed [ZW-1:0]   z_round;
  logic                   valid_a;
  logic signed [ANGW-1:0] angle_a;
  logic signed [15:0]     motor_a;

  logic signed [ANGW:0]   angle_diff;
  logic                   valid_b;
  logic signed [34:0]     servo_prod;
  logic signed [15:0]     motor_b;

  assign z_round = in_z + ZW'(32768);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      valid_b <= 1'b0;
    end else if (en) begin
      valid_a <= in_valid;
      valid_b <= valid_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle_a <= in_zero ? '0 : z_round[ZW-1:16];
      motor_a <= sat16(SATW'(in_motor >>> 1));
    end
  end

  assign angle_diff = {angle_a[ANGW-1], angle_a} - (ANGW+1)'(cfg.angle_offset);

  always_ff @(posedge clk) begin
    if (en) begin
      servo_prod <= angle_diff * cfg.angle_scale;
      motor_b    <= motor_a;
    end
  end

  assign out_valid             = valid_b;
  assign out_drive.motor_drive = motor_b;
  assign out_drive.servo_drive = sat16(SATW'(servo_prod >>> 7));

  `ADCM_ASSERT(a_back_angle_range, valid_a |-> angle_a <= 18'sd29000 && angle_a >= -18'sd29000, "angle out of range")

endmodule

[rtl/adcm_out_buf.sv]
`include "assert_macros.svh"

module adcm_out_buf
  import adcm_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   item_valid,
  input  drive_t item,
  output logic   en,
  output logic   drive_valid,
  input  logic   drive_ready,
  output drive_t drive
);

  logic   skid_valid;
  drive_t skid;
  logic   take;

  assign en   = !skid_valid;
  assign take = item_valid && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_valid <= 1'b0;
      skid_valid  <= 1'b0;
    end else if (drive_ready || !drive_valid) begin
      if (skid_valid) begin
        drive_valid <= 1'b1;
        skid_valid  <= 1'b0;
      end else begin
        drive_valid <= take;
      end
    end else if (take) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (drive_ready || !drive_valid) begin
      drive <= skid_valid ? skid : item;
    end else if (take) begin
      skid <= item;
    end
  end

  `ADCM_ASSERT(a_buf_skid_implies_out, skid_valid |-> drive_valid, "skid holds data with empty output")
  `ADCM_ASSERT(a_buf_skid_holds, skid_valid && !drive_ready |=> skid_valid, "skid dropped a stalled transfer")

endmodule

[rtl/ackermann_drive_command_mapper_top.sv]
// Channel   Valid        Ready        Payload
// cmd       cmd_valid    cmd_ready    cmd   (speed_command, turn_rate_command)
// drive     drive_valid  drive_ready  drive (motor_drive, servo_drive)
// cfg       cfg_wen      -            cfg_index, cfg_data
//
// One command pair enters per cycle while cmd_ready is high; the path is registered in
// two front stages (dead band, multipliers), one CORDIC stage per iteration,
// two back stages (round, servo multiply) and the output register.
// Synchronous reset clears valid bits and loads register defaults.
// A stall on drive parks one transfer in a skid register; cmd_ready drops while it is full.
module ackermann_drive_command_mapper_top
  import adcm_pkg::*;
#(
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  cmd_t        cmd,
  output logic        drive_valid,
  input  logic        drive_ready,
  output drive_t      drive,
  input  logic        cfg_wen,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int NUM_STAGES = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

  cfg_t cfg;
  logic en;

  logic                 f_valid;
  logic signed [XW-1:0] f_x;
  logic signed [XW-1:0] f_y;
  logic                 f_zero;
  logic signed [32:0]   f_motor;

  logic                 c_valid;
  logic signed [ZW-1:0] c_z;
  logic                 c_zero;
  logic signed [32:0]   c_motor;

  logic   b_valid;
  drive_t b_drive;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.speed_offset       <= 16'sd0;
      cfg.speed_scale        <= 16'sd256;
      cfg.angle_offset       <= 16'sd0;
      cfg.angle_scale        <= 16'sd256;
      cfg.forward_dead_band  <= 15'd0;
      cfg.backward_dead_band <= 16'sd0;
      cfg.axle_distance      <= 16'd0;
    end else if (cfg_wen) begin
      case (reg_idx_t'(cfg_index))
        REG_SPEED_OFFSET:       cfg.speed_offset       <= cfg_data;
        REG_SPEED_SCALE:        cfg.speed_scale        <= cfg_data;
        REG_ANGLE_OFFSET:       cfg.angle_offset       <= cfg_data;
        REG_ANGLE_SCALE:        cfg.angle_scale        <= cfg_data;
        REG_FORWARD_DEAD_BAND:  cfg.forward_dead_band  <= cfg_data[14:0];
        REG_BACKWARD_DEAD_BAND: cfg.backward_dead_band <= cfg_data;
        REG_AXLE_DISTANCE:      cfg.axle_distance      <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cmd_ready = en;

  adcm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cfg        (cfg),
    .valid      (f_valid),
    .x          (f_x),
    .y          (f_y),
    .zero       (f_zero),
    .motor_prod (f_motor)
  );

  adcm_cordic #(
    .STAGES (NUM_STAGES)
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .in_x      (f_x),
    .in_y      (f_y),
    .in_zero   (f_zero),
    .in_motor  (f_motor),
    .out_valid (c_valid),
    .out_z     (c_z),
    .out_zero  (c_zero),
    .out_motor (c_motor)
  );

  adcm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (c_valid),
    .in_z      (c_z),
    .in_zero   (c_zero),
    .in_motor  (c_motor),
    .cfg       (cfg),
    .out_valid (b_valid),
    .out_drive (b_drive)
  );

  adcm_out_buf u_out_buf (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (b_valid),
    .item        (b_drive),
    .en          (en),
    .drive_valid (drive_valid),
    .drive_ready (drive_ready),
    .drive       (drive)
  );

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import adcm_pkg::*;

  localparam int STAGES = 16;
  localparam int LATENCY = ((STAGES < 24) ? STAGES : 24) + 5;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [2:0] REG_UNUSED = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  cmd_t cmd = '0;
  logic drive_valid;
  logic drive_ready = 1'b0;
  drive_t drive;
  logic cfg_wen = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  cfg_t model_cfg;
  cmd_t pending_cmds [$];
  drive_t expected_drives [$];
  drive_t want_drive;
  bit steady = 1'b0;
  int errors = 0;
  int send_gap = 0;
  int stall_left = 0;
  int cycle_count = 0;

  ackermann_drive_command_mapper_top #(
    .CORDIC_STAGES(STAGES)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd(cmd),
    .drive_valid(drive_valid),
    .drive_ready(drive_ready),
    .drive(drive),
    .cfg_wen(cfg_wen),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint atan_step(int i);
    case (i)
      0: return 64'h3243F6A8;
      1: return 64'h1DAC6705;
      2: return 64'h0FADBAFC;
      3: return 64'h07F56EA6;
      4: return 64'h03FEAB76;
      5: return 64'h01FFD55B;
      6: return 64'h00FFFAAA;
      7: return 64'h007FFF55;
      8: return 64'h003FFFEA;
      9: return 64'h001FFFFD;
      10: return 64'h000FFFFF;
      11: return 64'h0007FFFF;
      12: return 64'h0003FFFF;
      13: return 64'h0001FFFF;
      14: return 64'h0000FFFF;
      15: return 64'h00007FFF;
      16: return 64'h00003FFF;
      17: return 64'h00001FFF;
      18: return 64'h00000FFF;
      19: return 64'h000007FF;
      20: return 64'h000003FF;
      21: return 64'h000001FF;
      22: return 64'h000000FF;
      default: return 64'h0000007F;
    endcase
  endfunction

  function automatic logic signed [15:0] clamp16(longint x);
    if (x > 32767) return 16'sh7FFF;
    if (x < -32768) return 16'sh8000;
    return x[15:0];
  endfunction

  function automatic drive_t predict_drive(cmd_t c);
    longint v, w, x, y, z, dx, dy, angle;
    int i;
    drive_t d;
    v = c.speed_command;
    w = c.turn_rate_command;
    angle = 0;
    if (v > 0 && v < longint'(model_cfg.forward_dead_band)) begin
      v = 0;
    end else if (v < 0 && v > longint'(model_cfg.backward_dead_band)) begin
      v = 0;
    end
    d.motor_drive = clamp16((v - longint'(model_cfg.speed_offset))
                            * longint'(model_cfg.speed_scale) >>> 1);
    if (v != 0 && w != 0 && model_cfg.axle_distance != 0) begin
      y = longint'(model_cfg.axle_distance) * w;
      if (v < 0) begin
        y = -y;
        x = -v * 4096;
      end else begin
        x = v * 4096;
      end
      z = 0;
      for (i = 0; i < STAGES && i < 24; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x += dx;
          y -= dy;
          z += atan_step(i);
        end else begin
          x -= dx;
          y += dy;
          z -= atan_step(i);
        end
      end
      angle = (z + 32768) >>> 16;
    end
    d.servo_drive = clamp16((angle - longint'(model_cfg.angle_offset))
                            * longint'(model_cfg.angle_scale) >>> 7);
    return d;
  endfunction

  function automatic int pick_idle();
    int r;
    if (steady) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [15:0] pick_value();
    case ($urandom_range(5))
      0: return 16'h0000;
      1: begin
        case ($urandom_range(3))
          0: return 16'h7FFF;
          1: return 16'h8000;
          2: return 16'h0001;
          default: return 16'hFFFF;
        endcase
      end
      2, 3: return 16'($urandom_range(512) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  // hit the dead band edges often
  function automatic logic [15:0] pick_speed();
    if ($urandom_range(3) != 0) return pick_value();
    if ($urandom_range(1) == 0) begin
      return 16'(int'(model_cfg.forward_dead_band) + int'($urandom_range(2)) - 1);
    end
    return 16'(int'(model_cfg.backward_dead_band) + int'($urandom_range(2)) - 1);
  endfunction

  task automatic queue_cmd(input logic [15:0] s, input logic [15:0] t);
    cmd_t c;
    c.speed_command = s;
    c.turn_rate_command = t;
    pending_cmds.push_back(c);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_SPEED_OFFSET: model_cfg.speed_offset = val;
      REG_SPEED_SCALE: model_cfg.speed_scale = val;
      REG_ANGLE_OFFSET: model_cfg.angle_offset = val;
      REG_ANGLE_SCALE: model_cfg.angle_scale = val;
      REG_FORWARD_DEAD_BAND: model_cfg.forward_dead_band = val[14:0];
      REG_BACKWARD_DEAD_BAND: model_cfg.backward_dead_band = val;
      REG_AXLE_DISTANCE: model_cfg.axle_distance = val;
      default: ;
    endcase
  endtask

  task automatic load_registers(input logic [15:0] s_off, input logic [15:0] s_gain,
                                input logic [15:0] a_off, input logic [15:0] a_gain,
                                input logic [15:0] fwd, input logic [15:0] bwd,
                                input logic [15:0] axle);
    write_reg(REG_SPEED_OFFSET, s_off);
    write_reg(REG_SPEED_SCALE, s_gain);
    write_reg(REG_ANGLE_OFFSET, a_off);
    write_reg(REG_ANGLE_SCALE, a_gain);
    write_reg(REG_FORWARD_DEAD_BAND, fwd);
    write_reg(REG_BACKWARD_DEAD_BAND, bwd);
    write_reg(REG_AXLE_DISTANCE, axle);
    // out of range index must leave every register alone
    write_reg(REG_UNUSED, 16'($urandom));
    @(posedge clk);
    cfg_wen <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    while (pending_cmds.size() != 0 || cmd_valid || expected_drives.size() != 0) begin
      @(negedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (cmd_valid && cmd_ready) begin
        expected_drives.push_back(predict_drive(cmd));
      end
      if (!cmd_valid || cmd_ready) begin
        if (send_gap > 0) begin
          cmd_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending_cmds.size() != 0) begin
          cmd_valid <= 1'b1;
          cmd <= pending_cmds.pop_front();
          send_gap <= pick_idle();
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      drive_ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (drive_valid && drive_ready) begin
        if (expected_drives.size() == 0) begin
          errors++;
          $error("drive transfer with nothing expected: motor_drive %0d, servo_drive %0d",
                 drive.motor_drive, drive.servo_drive);
        end else begin
          want_drive = expected_drives.pop_front();
          if (drive.motor_drive !== want_drive.motor_drive) begin
            errors++;
            $error("motor_drive: expected %0d, got %0d",
                   want_drive.motor_drive, drive.motor_drive);
          end
          if (drive.servo_drive !== want_drive.servo_drive) begin
            errors++;
            $error("servo_drive: expected %0d, got %0d",
                   want_drive.servo_drive, drive.servo_drive);
          end
        end
      end
      if (stall_left > 0) begin
        drive_ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        drive_ready <= 1'b1;
        stall_left <= pick_idle();
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int n;
    int p;
    model_cfg.speed_offset = 16'sd0;
    model_cfg.speed_scale = 16'sd256;
    model_cfg.angle_offset = 16'sd0;
    model_cfg.angle_scale = 16'sd256;
    model_cfg.forward_dead_band = 15'd0;
    model_cfg.backward_dead_band = 16'sd0;
    model_cfg.axle_distance = 16'd0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: zero axle distance, so the angle stays zero
    repeat (20) queue_cmd(pick_speed(), pick_value());
    wait_idle();

    // one metre axle, dead band of half a metre per second each way
    load_registers(16'h0000, 16'h0080, 16'h0000, 16'h0100, 16'h8080, 16'hFF80, 16'h1000);
    queue_cmd(16'h7FFF, 16'h7FFF);
    queue_cmd(16'h8000, 16'h8000);
    queue_cmd(16'h7FFF, 16'h8000);
    queue_cmd(16'h8000, 16'h7FFF);
    queue_cmd(16'h0000, 16'h0100);
    queue_cmd(16'h0100, 16'h0000);
    queue_cmd(16'h0040, 16'h0100);
    queue_cmd(16'h007F, 16'h0100);
    queue_cmd(16'h0080, 16'h0100);
    queue_cmd(16'hFFC0, 16'h0100);
    queue_cmd(16'hFF81, 16'h0100);
    queue_cmd(16'hFF80, 16'h0100);
    queue_cmd(16'h0100, 16'h0100);
    queue_cmd(16'hFF00, 16'h0100);
    queue_cmd(16'h0100, 16'hFF00);
    queue_cmd(16'hFF00, 16'hFF00);
    queue_cmd(16'h0081, 16'h7FFF);
    queue_cmd(16'hFF7F, 16'h8000);
    queue_cmd(16'h7FFF, 16'h0001);
    queue_cmd(16'h8000, 16'hFFFF);
    queue_cmd(16'h5555, 16'hAAAA);
    queue_cmd(16'hAAAA, 16'h5555);
    wait_idle();

    for (p = 0; p < 14; p++) begin
      steady = (p % 4 == 2);
      case (p)
        0: load_registers(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000,
                          16'h7FFF, 16'h8000, 16'hFFFF);
        // positive backward band zeroes nothing
        1: load_registers(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF,
                          16'h0000, 16'h0100, 16'h0001);
        default: begin
          if ($urandom_range(1) == 0) begin
            load_registers(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                           16'($urandom), 16'($urandom), 16'($urandom));
          end else begin
            load_registers(16'($urandom_range(512) - 256), 16'($urandom_range(1024) - 512),
                           16'($urandom_range(4096) - 2048), 16'($urandom_range(1024) - 512),
                           16'($urandom_range(300)), 16'(-int'($urandom_range(300))),
                           16'($urandom_range(16'h4000, 16'h0100)));
          end
        end
      endcase
      n = $urandom_range(150, 100);
      repeat (n) queue_cmd(pick_speed(), pick_value());
      wait_idle();
    end

    repeat (2 * LATENCY) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
